@@ sv/lnpfr_pkg.sv @@
// Shared types and constants for the link frame receiver.
`default_nettype none

package lnpfr_pkg;

    // Byte counter width; a frame is at most header, length, 255 data and checksum.
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] MAX_FRAME = 9'd258;

    localparam logic [7:0] HDR_MASK   = 8'hF8;
    localparam logic [7:0] HDR_BASE   = 8'hF0;
    localparam logic [7:0] SUM_INIT   = 8'hFF;
    localparam logic [7:0] BCAST_RST  = 8'hF0;
    localparam logic [7:0] ADDR_RST   = 8'hF1;

    // Register indexes on the configuration port (byte address bit 2).
    localparam logic REG_BROADCAST = 1'b0;
    localparam logic REG_ADDRESSED = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN   = 2'd0,
        KIND_BROADCAST = 2'd1,
        KIND_ADDRESSED = 2'd2,
        KIND_SHORT     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] broadcast_header;
        logic [7:0] addressed_header;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       checksum_ok;
        kind_t      frame_kind;
        logic [3:0] dest_host;
        logic [3:0] dest_port;
        logic [3:0] src_host;
        logic [3:0] src_port;
        logic [7:0] payload_length;
    } result_t;

endpackage

`default_nettype wire

@@ sv/lnpfr_cfg.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module lnpfr_cfg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lnpfr_pkg::cfg_t      cfg
);

    logic [7:0] bcast_reg, bcast_next;
    logic [7:0] addr_reg, addr_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        bcast_next = bcast_reg;
        addr_next  = addr_reg;
        if (wr_en) begin
            case (paddr[2])
                lnpfr_pkg::REG_BROADCAST: bcast_next = pwdata[7:0];
                lnpfr_pkg::REG_ADDRESSED: addr_next  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcast_reg <= lnpfr_pkg::BCAST_RST;
            addr_reg  <= lnpfr_pkg::ADDR_RST;
        end else begin
            bcast_reg <= bcast_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb begin
        case (paddr[2])
            lnpfr_pkg::REG_BROADCAST: prdata = {24'd0, bcast_reg};
            lnpfr_pkg::REG_ADDRESSED: prdata = {24'd0, addr_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.broadcast_header = bcast_reg;
    assign cfg.addressed_header = addr_reg;

endmodule

`default_nettype wire

@@ sv/lnpfr_parser.sv @@
// Frame state machine, running checksum and per-byte result logic.
`default_nettype none

module lnpfr_parser #(
    parameter logic [lnpfr_pkg::COUNT_W-1:0] MAX_FRAME = lnpfr_pkg::MAX_FRAME
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [7:0]          rx_byte,
    input  wire lnpfr_pkg::cfg_t     cfg,
    output lnpfr_pkg::result_t       result
);

    lnpfr_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [lnpfr_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [lnpfr_pkg::COUNT_W-1:0] count_cur, count_inc;
    logic [lnpfr_pkg::COUNT_W-1:0] data_end_reg, data_end_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] header_seen_reg, header_seen_next;
    logic [7:0] length_seen_reg, length_seen_next;
    logic [7:0] dest_byte_reg, dest_byte_next;
    logic [7:0] src_byte_reg, src_byte_next;
    logic [7:0] data_idx;
    logic       restart;
    lnpfr_pkg::kind_t kind;

    // Kind follows the stored header and the registers as they stand now.
    always_comb begin
        if (header_seen_reg == cfg.addressed_header) begin
            kind = (length_seen_reg < 8'd2) ? lnpfr_pkg::KIND_SHORT
                                            : lnpfr_pkg::KIND_ADDRESSED;
        end else if (header_seen_reg == cfg.broadcast_header) begin
            kind = lnpfr_pkg::KIND_BROADCAST;
        end else begin
            kind = lnpfr_pkg::KIND_UNKNOWN;
        end
    end

    always_comb begin
        // A frame that ran past the limit restarts the hunt on this byte.
        restart   = (byte_count_reg >= MAX_FRAME) ||
                    (phase_reg == lnpfr_pkg::PH_HUNT);
        phase_cur = restart ? lnpfr_pkg::PH_HUNT : phase_reg;
        count_cur = restart ? '0 : byte_count_reg;
        count_inc = count_cur + 9'd1;
        data_idx  = count_inc[7:0] - 8'd3;

        phase_next       = phase_cur;
        byte_count_next  = count_inc;
        data_end_next    = data_end_reg;
        running_sum_next = running_sum_reg + rx_byte;
        header_seen_next = header_seen_reg;
        length_seen_next = length_seen_reg;
        dest_byte_next   = dest_byte_reg;
        src_byte_next    = src_byte_reg;
        result           = '0;

        case (phase_cur)
            lnpfr_pkg::PH_HUNT: begin
                header_seen_next = rx_byte;
                running_sum_next = lnpfr_pkg::SUM_INIT + rx_byte;
                length_seen_next = 8'd0;
                data_end_next    = '0;
                dest_byte_next   = 8'd0;
                src_byte_next    = 8'd0;
                if ((rx_byte & lnpfr_pkg::HDR_MASK) == lnpfr_pkg::HDR_BASE) begin
                    phase_next = lnpfr_pkg::PH_LEN;
                end
            end
            lnpfr_pkg::PH_LEN: begin
                length_seen_next = rx_byte;
                data_end_next    = {1'b0, rx_byte} + 9'd2;
                phase_next       = (rx_byte == 8'd0) ? lnpfr_pkg::PH_SUM
                                                     : lnpfr_pkg::PH_DATA;
            end
            lnpfr_pkg::PH_DATA: begin
                if (data_idx == 8'd0) begin
                    dest_byte_next = rx_byte;
                end else if (data_idx == 8'd1) begin
                    src_byte_next = rx_byte;
                end
                // Addressed frames spend their first two data bytes on the address.
                if (kind == lnpfr_pkg::KIND_ADDRESSED || kind == lnpfr_pkg::KIND_SHORT) begin
                    if (data_idx >= 8'd2) begin
                        result.payload_valid = 1'b1;
                        result.payload_byte  = rx_byte;
                        result.payload_index = data_idx - 8'd2;
                    end
                end else begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = data_idx;
                end
                if (count_inc == data_end_reg) begin
                    phase_next = lnpfr_pkg::PH_SUM;
                end
            end
            lnpfr_pkg::PH_SUM: begin
                result.frame_done  = 1'b1;
                result.checksum_ok = (rx_byte == running_sum_reg);
                result.frame_kind  = kind;
                if (kind == lnpfr_pkg::KIND_ADDRESSED) begin
                    result.dest_host      = dest_byte_reg[7:4];
                    result.dest_port      = dest_byte_reg[3:0];
                    result.src_host       = src_byte_reg[7:4];
                    result.src_port       = src_byte_reg[3:0];
                    result.payload_length = length_seen_reg - 8'd2;
                end else if (kind != lnpfr_pkg::KIND_SHORT) begin
                    result.payload_length = length_seen_reg;
                end
                phase_next = lnpfr_pkg::PH_HUNT;
            end
            default: begin
                phase_next = lnpfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= lnpfr_pkg::PH_HUNT;
            byte_count_reg  <= '0;
            data_end_reg    <= '0;
            running_sum_reg <= lnpfr_pkg::SUM_INIT;
            header_seen_reg <= 8'd0;
            length_seen_reg <= 8'd0;
            dest_byte_reg   <= 8'd0;
            src_byte_reg    <= 8'd0;
        end else if (step) begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            data_end_reg    <= data_end_next;
            running_sum_reg <= running_sum_next;
            header_seen_reg <= header_seen_next;
            length_seen_reg <= length_seen_next;
            dest_byte_reg   <= dest_byte_next;
            src_byte_reg    <= src_byte_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lnp_frame_receiver_top.sv @@
// Link frame receiver: one received byte in, one result word out.
//
// The s_ channel takes one received link byte per word in s_tdata. Every
// accepted byte produces exactly one word on the m_ channel: m_tlast marks
// the checksum byte that ends a frame, tuser flags a payload byte and gives
// the frame kind, and tdata carries the payload byte, its index, the checksum
// verdict, address nibbles and payload length.
// Frame headers are matched against two registers on the APB-style port.
// The result word for a byte passes through the input register and then
// the result register: the frame state machine and the checksum adder
// between the two produce the word that the result register captures.
// Throughput is one byte per cycle while m_ does not stall; the per-byte
// update is the 8-bit checksum add, the byte counter and index arithmetic
// and a few compares. The input register accepts a new byte while a
// finished result still waits on m_.
// When the m_ side stalls, the result register holds and the input register
// fills; s_tready then drops until m_tready returns.
// A synchronous low aresetn empties both registers, returns the receiver to
// hunting for a header and restores the header registers to 0xF0 and 0xF1.
`default_nettype none

module lnp_frame_receiver_top #(
    parameter logic [lnpfr_pkg::COUNT_W-1:0] MAX_FRAME = lnpfr_pkg::MAX_FRAME
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [16] checksum_ok,
    // [20:17] dest_host, [24:21] dest_port, [28:25] src_host,
    // [32:29] src_port, [40:33] payload_length, [47:41] zero
    output logic [47:0]      m_tdata,
    output logic             m_tlast,   // frame_done
    // [0] payload_valid, [2:1] frame_kind
    output logic [2:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    lnpfr_pkg::cfg_t    cfg;
    lnpfr_pkg::result_t result;
    lnpfr_pkg::result_t out_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    lnpfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lnpfr_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.payload_length, out_reg.src_port, out_reg.src_host,
                       out_reg.dest_port, out_reg.dest_host, out_reg.checksum_ok,
                       out_reg.payload_index, out_reg.payload_byte};
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = {out_reg.frame_kind, out_reg.payload_valid};

endmodule

`default_nettype wire

@@ sv/lnpfr_checker.sv @@
// Port-level checks for the link frame receiver, bound to the top level.
`default_nettype none

module lnpfr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser
);

    // A stalled result word must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A byte is either payload, a frame end, or neither.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tlast))
        else $error("payload and frame end in the same word");

    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0 && m_tdata[40:16] == 25'd0)
        else $error("frame end fields set without a frame end");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("payload fields set on a non-payload word");

endmodule

bind lnp_frame_receiver_top lnpfr_checker u_lnpfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/sv/tb_lnp_frame_receiver_top.sv @@
// Self-checking testbench for the link frame receiver, driven through its stream and APB ports.
`timescale 1ns / 1ps

module tb_lnp_frame_receiver_top;

    typedef struct {
        logic [7:0]         rx;
        bit                 typed;
        lnpfr_pkg::result_t word;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    lnp_frame_receiver_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    // Receiver state as the predictor sees it.
    lnpfr_pkg::cfg_t                  hdr_cfg;
    lnpfr_pkg::phase_t                rx_phase;
    logic [lnpfr_pkg::COUNT_W-1:0]    rx_count;
    logic [lnpfr_pkg::COUNT_W-1:0]    rx_end;
    logic [7:0]       rx_sum;
    logic [7:0]       rx_header;
    logic [7:0]       rx_length;
    logic [7:0]       rx_dest;
    logic [7:0]       rx_src;

    lnpfr_pkg::result_t awaited_results[$];
    stim_row_t directed_rows[$];
    int        mismatches = 0;
    int        bytes_sent = 0;
    int        noise_sent = 0;
    int        frame_ends = 0;
    int        bad_sums = 0;
    int        payload_seen = 0;
    int        stall_left = 0;
    bit        quiet = 1'b0;

    function automatic lnpfr_pkg::kind_t header_kind();
        if (rx_header == hdr_cfg.addressed_header)
            return (rx_length < 8'd2) ? lnpfr_pkg::KIND_SHORT : lnpfr_pkg::KIND_ADDRESSED;
        if (rx_header == hdr_cfg.broadcast_header)
            return lnpfr_pkg::KIND_BROADCAST;
        return lnpfr_pkg::KIND_UNKNOWN;
    endfunction

    function automatic lnpfr_pkg::result_t decode_link_byte(input logic [7:0] b);
        lnpfr_pkg::result_t            r;
        logic [lnpfr_pkg::COUNT_W-1:0] idx;
        lnpfr_pkg::kind_t              k;
        r = '0;
        if (rx_count >= lnpfr_pkg::MAX_FRAME || rx_phase == lnpfr_pkg::PH_HUNT) begin
            rx_phase = lnpfr_pkg::PH_HUNT;
            rx_count = '0;
        end
        rx_count = rx_count + 1'b1;
        case (rx_phase)
            lnpfr_pkg::PH_HUNT: begin
                rx_header = b;
                rx_sum    = lnpfr_pkg::SUM_INIT + b;
                rx_length = 8'd0;
                rx_end    = '0;
                rx_dest   = 8'd0;
                rx_src    = 8'd0;
                if ((b & lnpfr_pkg::HDR_MASK) == lnpfr_pkg::HDR_BASE)
                    rx_phase = lnpfr_pkg::PH_LEN;
            end
            lnpfr_pkg::PH_LEN: begin
                rx_length = b;
                rx_end    = {1'b0, b} + 9'd2;
                rx_sum    = rx_sum + b;
                rx_phase  = (b == 8'd0) ? lnpfr_pkg::PH_SUM : lnpfr_pkg::PH_DATA;
            end
            lnpfr_pkg::PH_DATA: begin
                idx    = rx_count - 9'd3;
                rx_sum = rx_sum + b;
                if (idx == 9'd0)
                    rx_dest = b;
                else if (idx == 9'd1)
                    rx_src = b;
                k = header_kind();
                // Addressed frames spend their first two data bytes on the address.
                if (k == lnpfr_pkg::KIND_ADDRESSED || k == lnpfr_pkg::KIND_SHORT) begin
                    if (idx >= 9'd2) begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        r.payload_index = idx[7:0] - 8'd2;
                    end
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = idx[7:0];
                end
                if (rx_count == rx_end)
                    rx_phase = lnpfr_pkg::PH_SUM;
            end
            default: begin
                k = header_kind();
                r.frame_done  = 1'b1;
                r.checksum_ok = (b == rx_sum);
                r.frame_kind  = k;
                if (k == lnpfr_pkg::KIND_ADDRESSED) begin
                    r.dest_host      = rx_dest[7:4];
                    r.dest_port      = rx_dest[3:0];
                    r.src_host       = rx_src[7:4];
                    r.src_port       = rx_src[3:0];
                    r.payload_length = rx_length - 8'd2;
                end else if (k != lnpfr_pkg::KIND_SHORT) begin
                    r.payload_length = rx_length;
                end
                rx_phase = lnpfr_pkg::PH_HUNT;
            end
        endcase
        return r;
    endfunction

    function automatic lnpfr_pkg::result_t frame_end(input bit ok, input lnpfr_pkg::kind_t k,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] len);
        lnpfr_pkg::result_t r;
        r = '0;
        r.frame_done     = 1'b1;
        r.checksum_ok    = ok;
        r.frame_kind     = k;
        {r.dest_host, r.dest_port, r.src_host, r.src_port} = addr;
        r.payload_length = len;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic [7:0] b);
        stim_row_t row;
        row.rx = b;
        row.typed = 1'b0;
        row.word = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_row_expect(input logic [7:0] b, input lnpfr_pkg::result_t w);
        stim_row_t row;
        row.rx = b;
        row.typed = 1'b1;
        row.word = w;
        directed_rows.push_back(row);
    endtask

    // Offers one byte after a random gap; the prediction is made at acceptance.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input lnpfr_pkg::result_t w);
        int                 gap;
        lnpfr_pkg::result_t r;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        r = decode_link_byte(b);
        awaited_results.push_back(typed ? w : r);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_header_reg(input logic reg_sel, input logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == lnpfr_pkg::REG_BROADCAST)
            hdr_cfg.broadcast_header = value;
        else
            hdr_cfg.addressed_header = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends a frame with random data; a bad checksum or an early cut breaks it.
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len,
                              input bit corrupt, input bit truncate);
        logic [7:0] sum;
        logic [7:0] d;
        int         n;
        sum = lnpfr_pkg::SUM_INIT + hdr + len;
        n = truncate ? $urandom_range(0, len) : len;
        send_plain(hdr);
        send_plain(len);
        for (int i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 255));
            sum = sum + d;
            send_plain(d);
        end
        if (!truncate)
            send_plain(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    function automatic logic [7:0] pick_header();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return hdr_cfg.broadcast_header;
        if (r < 8) return hdr_cfg.addressed_header;
        return lnpfr_pkg::HDR_BASE | 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'($urandom_range(0, 2));
        if (r < 85) return 8'($urandom_range(3, 12));
        return 8'($urandom_range(13, 48));
    endfunction

    task automatic random_traffic(input int budget, input bit long_frame);
        int start;
        int r;
        start = bytes_sent - noise_sent;
        if (long_frame)
            send_frame(pick_header(), 8'd255, 1'b0, 1'b0);
        while (bytes_sent - noise_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_plain(8'($urandom_range(0, 255)));
                noise_sent++;
            end else begin
                if (r < 10)
                    wait_drained();
                send_frame(pick_header(), pick_length(),
                           $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 5);
            end
        end
    endtask

    // Result side stall pattern.
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left <= idle_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        lnpfr_pkg::result_t got;
        lnpfr_pkg::result_t want;
        string              bad;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.payload_valid  = m_tuser[0];
            got.frame_done     = m_tlast;
            got.frame_kind     = lnpfr_pkg::kind_t'(m_tuser[2:1]);
            got.payload_byte   = m_tdata[7:0];
            got.payload_index  = m_tdata[15:8];
            got.checksum_ok    = m_tdata[16];
            got.dest_host      = m_tdata[20:17];
            got.dest_port      = m_tdata[24:21];
            got.src_host       = m_tdata[28:25];
            got.src_port       = m_tdata[32:29];
            got.payload_length = m_tdata[40:33];
            if (got.payload_valid) payload_seen++;
            if (got.frame_done) begin
                frame_ends++;
                if (!got.checksum_ok) bad_sums++;
            end
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h at %0t", got, $realtime);
            end else begin
                want = awaited_results.pop_front();
                bad = "";
                if (got.payload_valid !== want.payload_valid)   bad = {bad, " payload_valid"};
                if (got.payload_byte !== want.payload_byte)     bad = {bad, " payload_byte"};
                if (got.payload_index !== want.payload_index)   bad = {bad, " payload_index"};
                if (got.frame_done !== want.frame_done)         bad = {bad, " frame_done"};
                if (got.checksum_ok !== want.checksum_ok)       bad = {bad, " checksum_ok"};
                if (got.frame_kind !== want.frame_kind)         bad = {bad, " frame_kind"};
                if (got.dest_host !== want.dest_host)           bad = {bad, " dest_host"};
                if (got.dest_port !== want.dest_port)           bad = {bad, " dest_port"};
                if (got.src_host !== want.src_host)             bad = {bad, " src_host"};
                if (got.src_port !== want.src_port)             bad = {bad, " src_port"};
                if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected %h got %h, fields:%s",
                                 $realtime, want, got, bad);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_lnp_frame_receiver_top NOT OK");
        $finish;
    end

    initial begin
        hdr_cfg.broadcast_header = lnpfr_pkg::BCAST_RST;
        hdr_cfg.addressed_header = lnpfr_pkg::ADDR_RST;
        rx_phase  = lnpfr_pkg::PH_HUNT;
        rx_count  = '0;
        rx_end    = '0;
        rx_sum    = lnpfr_pkg::SUM_INIT;
        rx_header = 8'd0;
        rx_length = 8'd0;
        rx_dest   = 8'd0;
        rx_src    = 8'd0;

        // Noise while hunting, then a zero-length broadcast frame.
        add_row_expect(8'h00, '0);
        add_row_expect(8'hFF, '0);
        add_row_expect(8'hF0, '0);
        add_row_expect(8'h00, '0);
        add_row_expect(8'hEF, frame_end(1'b1, lnpfr_pkg::KIND_BROADCAST, 16'h0000, 8'd0));
        // Addressed frame that carries only its two address bytes.
        add_row_expect(8'hF1, '0);
        add_row_expect(8'h02, '0);
        add_row(8'hAB);
        add_row(8'hCD);
        add_row_expect(8'h6A, frame_end(1'b1, lnpfr_pkg::KIND_ADDRESSED, 16'hABCD, 8'd0));
        // Addressed frame too short for an address, with a wrong checksum.
        add_row(8'hF1);
        add_row(8'h01);
        add_row(8'h5A);
        add_row_expect(8'h00, frame_end(1'b0, lnpfr_pkg::KIND_SHORT, 16'h0000, 8'd0));
        // Unknown header: all data is payload.
        add_row(8'hF7);
        add_row(8'h03);
        add_row(8'h00);
        add_row(8'hFF);
        add_row(8'h80);
        add_row_expect(8'h78, frame_end(1'b1, lnpfr_pkg::KIND_UNKNOWN, 16'h0000, 8'd3));
        // Addressed header with zero length.
        add_row(8'hF1);
        add_row(8'h00);
        add_row_expect(8'hF0, frame_end(1'b1, lnpfr_pkg::KIND_SHORT, 16'h0000, 8'd0));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].word);
        random_traffic(280, 1'b1);
        wait_drained();

        quiet = 1'b1;
        write_header_reg(lnpfr_pkg::REG_BROADCAST, 8'hF7);
        write_header_reg(lnpfr_pkg::REG_ADDRESSED, 8'hF0);
        random_traffic(300, 1'b0);
        wait_drained();

        // Equal registers: the addressed kind takes precedence.
        quiet = 1'b0;
        write_header_reg(lnpfr_pkg::REG_BROADCAST, 8'hF3);
        write_header_reg(lnpfr_pkg::REG_ADDRESSED, 8'hF3);
        random_traffic(300, 1'b0);
        wait_drained();

        write_header_reg(lnpfr_pkg::REG_BROADCAST, 8'hF0);
        write_header_reg(lnpfr_pkg::REG_ADDRESSED, 8'hF7);
        random_traffic(300, 1'b0);
        wait_drained();

        write_header_reg(lnpfr_pkg::REG_BROADCAST,
                         lnpfr_pkg::HDR_BASE | 8'($urandom_range(0, 3)));
        write_header_reg(lnpfr_pkg::REG_ADDRESSED,
                         lnpfr_pkg::HDR_BASE | 8'($urandom_range(4, 7)));
        random_traffic(300, 1'b1);
        wait_drained();
        repeat (10) @(posedge aclk);

        mismatches += awaited_results.size();
        $display("Sent %0d bytes (%0d of them hunt noise) over five header settings.",
                 bytes_sent, noise_sent);
        $display("Checked %0d payload bytes and %0d frame ends, %0d with a bad checksum.",
                 payload_seen, frame_ends, bad_sums);
        if (mismatches == 0) begin
            $display("tb_lnp_frame_receiver_top OK");
        end else begin
            $display("tb_lnp_frame_receiver_top NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lnpfr_pkg.sv
sv/lnpfr_cfg.sv
sv/lnpfr_parser.sv
sv/lnp_frame_receiver_top.sv
sv/lnpfr_checker.sv
tb/sv/tb_lnp_frame_receiver_top.sv
